// ----- rtl/netc_pkg.sv -----
// shared types, codes and helpers for the numeric element type converter
package netc_pkg;

  typedef enum logic [3:0] {
    SRC_F32 = 4'd0, SRC_F64 = 4'd1, SRC_I8 = 4'd2, SRC_U8 = 4'd3,
    SRC_I16 = 4'd4, SRC_U16 = 4'd5, SRC_I32 = 4'd6, SRC_U32 = 4'd7,
    SRC_I64 = 4'd8, SRC_U64 = 4'd9
  } src_code_t;

  localparam logic [1:0] TGT_INT  = 2'd0;
  localparam logic [1:0] TGT_DBL  = 2'd1;
  localparam logic [1:0] TGT_PASS = 2'd2;

  localparam logic [0:0] REG_SOURCE = 1'b0;
  localparam logic [0:0] REG_TARGET = 1'b1;

  // routing of one element through the pipe
  typedef struct packed {
    logic       last;
    logic       pass;    // copy raw bits
    logic       terr;    // unsupported source
    logic       is_int;  // integer source
    logic       to_int;  // target is int64
  } ctl_t;

  // position of the highest set bit, 6 bits
  function automatic logic [5:0] msb_pos(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

// ----- rtl/numeric_element_type_converter_unit.sv -----
// top level of the numeric element type converter
//
// channel  dir  payload
// in_      in   tdata raw_bits[63:0], tlast last_in
// out_     out  tdata value_bits[63:0], tlast last_out, tuser {range_flag, type_error}
// cfg_     in   index 0 source_type, 1 target_type
//
// one element per cycle when not stalled; the result is registered through five
// register stages: decode, three conversion stages, output.
// rst_n clears the valid bits and sets source f32, target pass; data registers are not reset.
// a stall freezes the whole pipe; in_tready is high when out_tready is high or no output is valid.
module numeric_element_type_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // raw_bits
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // value_bits
  output logic        out_tlast,  // last_out
  output logic [1:0]  out_tuser,  // {range_flag, type_error}
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import netc_pkg::*;

  logic [3:0]  src_r;
  logic [1:0]  tgt_r;
  logic [4:0]  vld_r;
  ctl_t        ctl_r [5];
  logic [63:0] raw_r [4];
  logic [63:0] ival_r, dbits_r;
  logic        uns_r;
  logic [63:0] out_val_r;
  logic        out_terr_r, out_rflag_r;
  logic        en;

  logic [63:0] ival_nxt, dbits_nxt, f64w, d2i_v, i2d_v, res_nxt;
  logic        d2i_f;
  ctl_t        ctl_nxt;
  logic [31:0] f;
  logic [22:0] fm, fmn;
  logic [5:0]  fp_full;
  logic [4:0]  fp;

  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= SRC_F32;
      tgt_r <= TGT_PASS;
    end else if (cfg_we) begin
      if (cfg_index == REG_SOURCE) src_r <= cfg_wdata;
      else                         tgt_r <= cfg_wdata[1:0];
    end
  end

  // f32 widening
  assign f       = in_tdata[31:0];
  assign fm      = f[22:0];
  assign fp_full = msb_pos({41'd0, fm});
  assign fp      = fp_full[4:0];
  assign fmn     = fm << (5'd23 - fp);
  always_comb begin
    if (f[30:23] == 8'hFF)
      f64w = {f[31], 11'h7FF, (fm != 0), fm[21:0], 29'd0} | {12'd0, 52'd0};
    else if (f[30:23] == 8'd0)
      f64w = (fm == 0) ? {f[31], 63'd0}
           : {f[31], 11'(11'd874 + {6'd0, fp}), fmn, 29'd0};
    else
      f64w = {f[31], 11'({3'd0, f[30:23]} + 11'd896), fm, 29'd0};
    if (f[30:23] == 8'hFF && fm != 0)
      f64w = {f[31], 11'h7FF, 1'b1, fm[21:0], 29'd0};
  end

  always_comb begin
    ival_nxt  = in_tdata;
    dbits_nxt = in_tdata;
    ctl_nxt   = '{last: in_tlast, pass: tgt_r[1], terr: 1'b0, is_int: 1'b1,
                  to_int: (tgt_r == TGT_INT)};
    case (src_r)
      SRC_F32: begin ctl_nxt.is_int = 1'b0; dbits_nxt = f64w; end
      SRC_F64: ctl_nxt.is_int = 1'b0;
      SRC_I8:  ival_nxt = {{56{in_tdata[7]}}, in_tdata[7:0]};
      SRC_U8:  ival_nxt = {56'd0, in_tdata[7:0]};
      SRC_I16: ival_nxt = {{48{in_tdata[15]}}, in_tdata[15:0]};
      SRC_U16: ival_nxt = {48'd0, in_tdata[15:0]};
      SRC_I32: ival_nxt = {{32{in_tdata[31]}}, in_tdata[31:0]};
      SRC_U32: ival_nxt = {32'd0, in_tdata[31:0]};
      SRC_I64, SRC_U64: ;
      default: ctl_nxt.terr = ~tgt_r[1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[3:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_nxt;
      raw_r[0] <= in_tdata;
      ival_r   <= ival_nxt;
      dbits_r  <= dbits_nxt;
      uns_r    <= (src_r == SRC_U64);
      for (int i = 1; i < 5; i++) ctl_r[i] <= ctl_r[i-1];
      for (int i = 1; i < 4; i++) raw_r[i] <= raw_r[i-1];
    end
  end

  netc_i2d u_i2d (.clk, .en, .ival(ival_r), .uns(uns_r), .dbits(i2d_v));
  netc_d2i u_d2i (.clk, .en, .dbits(dbits_r), .ival(d2i_v), .rflag(d2i_f));

  // delayed copies of the decoded values for the direct cases
  logic [63:0] iv_d_r [3];
  logic [63:0] dv_d_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      iv_d_r[0] <= ival_r; dv_d_r[0] <= dbits_r;
      for (int i = 1; i < 3; i++) begin
        iv_d_r[i] <= iv_d_r[i-1];
        dv_d_r[i] <= dv_d_r[i-1];
      end
    end
  end

  always_comb begin
    if (ctl_r[3].pass)       res_nxt = raw_r[3];
    else if (ctl_r[3].terr)  res_nxt = 64'd0;
    else if (ctl_r[3].to_int) res_nxt = ctl_r[3].is_int ? iv_d_r[2] : d2i_v;
    else                     res_nxt = ctl_r[3].is_int ? i2d_v : dv_d_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r   <= res_nxt;
      out_terr_r  <= ctl_r[3].terr;
      out_rflag_r <= ~ctl_r[3].pass & ~ctl_r[3].terr & ctl_r[3].to_int
                     & ~ctl_r[3].is_int & d2i_f;
    end
  end

  assign out_tvalid = vld_r[4];
  assign out_tdata  = out_val_r;
  assign out_tlast  = ctl_r[4].last;
  assign out_tuser  = {out_rflag_r, out_terr_r};
endmodule

// ----- rtl/netc_i2d.sv -----
// integer to double conversion, three register stages
module netc_i2d (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] ival,
  input  logic        uns,
  output logic [63:0] dbits
);
  import netc_pkg::*;

  logic        s1_sign_r, s1_zero_r;
  logic [63:0] s1_mag_r;
  logic [5:0]  s1_pos_r;
  logic        s2_sign_r, s2_zero_r;
  logic [5:0]  s2_pos_r;
  logic [63:0] s2_norm_r;
  logic [63:0] s3_bits_r;

  logic        neg;
  logic [63:0] mag;
  logic [52:0] mant;
  logic        rbit, sticky, rup;
  logic [53:0] mround;
  logic [10:0] expo;

  assign neg = ~uns & ival[63];
  assign mag = neg ? (~ival + 64'd1) : ival;

  // stage 2: mantissa with round to nearest even
  assign mant   = s2_norm_r[63:11];
  assign rbit   = s2_norm_r[10];
  assign sticky = |s2_norm_r[9:0];
  assign rup    = rbit & (sticky | mant[0]);
  assign mround = {1'b0, mant} + {53'd0, rup};
  assign expo   = 11'd1023 + {5'd0, s2_pos_r} + {10'd0, mround[53]};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign_r <= neg;
      s1_zero_r <= (ival == 64'd0);
      s1_mag_r  <= mag;
      s1_pos_r  <= msb_pos(mag);
      s2_sign_r <= s1_sign_r;
      s2_zero_r <= s1_zero_r;
      s2_pos_r  <= s1_pos_r;
      s2_norm_r <= s1_mag_r << (6'd63 - s1_pos_r);
      s3_bits_r <= s2_zero_r ? 64'd0 :
                   {s2_sign_r, expo, mround[53] ? mround[52:1] : mround[51:0]};
    end
  end

  assign dbits = s3_bits_r;
endmodule

// ----- rtl/netc_d2i.sv -----
// double to int64 truncation with saturation, three register stages
module netc_d2i (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] dbits,
  output logic [63:0] ival,
  output logic        rflag
);
  import netc_pkg::*;

  logic        s1_sign_r, s1_nan_r, s1_big_r, s1_small_r;
  logic [6:0]  s1_sh_r;
  logic [63:0] s1_man_r;
  logic        s2_sign_r, s2_nan_r, s2_big_r, s2_small_r;
  logic [63:0] s2_mag_r;
  logic [63:0] s3_val_r;
  logic        s3_flag_r;

  logic [10:0] e;
  logic        over;

  assign e = dbits[62:52];
  // |value| >= 2^63 when exponent >= 1086
  assign over = (e >= 11'd1086);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign_r  <= dbits[63];
      s1_nan_r   <= (e == 11'h7FF) && (dbits[51:0] != 52'd0);
      s1_big_r   <= over && !dbits[63];
      s1_small_r <= over && dbits[63] && !(e == 11'd1086 && dbits[51:0] == 52'd0);
      // below one in magnitude: shift everything out
      s1_sh_r    <= (e < 11'd1023) ? 7'd127 : 7'(11'd1075 - e + 11'd64);
      s1_man_r   <= {11'd0, 1'b1, dbits[51:0]};
      s2_sign_r  <= s1_sign_r;
      s2_nan_r   <= s1_nan_r;
      s2_big_r   <= s1_big_r;
      s2_small_r <= s1_small_r;
      // shift code: 64 means no shift, below 64 left, above 64 right
      if (s1_sh_r >= 7'd64)
        s2_mag_r <= (s1_sh_r - 7'd64 > 7'd63) ? 64'd0 : s1_man_r >> (s1_sh_r - 7'd64);
      else
        s2_mag_r <= s1_man_r << (7'd64 - s1_sh_r);
      s3_flag_r  <= s2_nan_r | s2_big_r | s2_small_r;
      if (s2_nan_r)        s3_val_r <= 64'd0;
      else if (s2_big_r)   s3_val_r <= 64'h7FFF_FFFF_FFFF_FFFF;
      else if (s2_small_r) s3_val_r <= 64'h8000_0000_0000_0000;
      else                 s3_val_r <= s2_sign_r ? (~s2_mag_r + 64'd1) : s2_mag_r;
    end
  end

  assign ival  = s3_val_r;
  assign rflag = s3_flag_r;
endmodule

// ----- verif/numeric_element_type_converter_unit_tb.sv -----
// testbench for the numeric element type converter: random stream with a scoreboard
module numeric_element_type_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import netc_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic        last;
    logic        terr;
    logic        rflag;
  } conv_result_t;

  class conv_scoreboard;
    logic [3:0]   src;
    logic [1:0]   tgt;
    conv_result_t pending[$];
    int           errors;
    int           matched;

    function new();
      src = SRC_F32;
      tgt = TGT_PASS;
      errors = 0;
      matched = 0;
    endfunction

    function void set_reg(logic idx, logic [3:0] v);
      if (idx == REG_SOURCE) src = v;
      else tgt = v[1:0];
    endfunction

    function logic [63:0] widen_f32(logic [31:0] f);
      logic [23:0] man;
      int          ex;
      man = {1'b0, f[22:0]};
      ex = 1;
      if (f[30:23] == 8'hff) begin
        if (f[22:0] != 0) return {f[31], 11'h7ff, 1'b1, f[21:0], 29'b0};
        return {f[31], 11'h7ff, 52'b0};
      end
      if (f[30:23] == 8'h00) begin
        if (f[22:0] == 0) return {f[31], 63'b0};
        while (!man[23]) begin
          man = man << 1;
          ex--;
        end
        return {f[31], 11'(ex + 896), man[22:0], 29'b0};
      end
      return {f[31], 11'(int'(f[30:23]) + 896), f[22:0], 29'b0};
    endfunction

    // magnitude to double, round to nearest even
    function logic [63:0] int_to_real(logic neg, logic [63:0] mag);
      int          p;
      int          sh;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      p = 0;
      if (mag == 0) return 64'd0;
      for (int i = 0; i < 64; i++) if (mag[i]) p = i;
      if (p <= 52) begin
        kept = mag << (52 - p);
      end else begin
        sh = p - 52;
        kept = mag >> sh;
        rem = mag & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 1;
        if (kept[53]) begin
          kept = kept >> 1;
          p++;
        end
      end
      return {neg, 11'(p + 1023), kept[51:0]};
    endfunction

    // truncate toward zero, saturate, nan gives zero
    function logic [63:0] real_to_int(logic [63:0] b, output logic flag);
      int          ue;
      logic [63:0] mg;
      flag = 1'b0;
      ue = int'(b[62:52]) - 1023;
      if (b[62:52] == 11'h7ff && b[51:0] != 0) begin
        flag = 1'b1;
        return 64'd0;
      end
      if (!b[63] && ue >= 63) begin
        flag = 1'b1;
        return 64'h7fff_ffff_ffff_ffff;
      end
      if (b[63] && (ue > 63 || (ue == 63 && b[51:0] != 0))) begin
        flag = 1'b1;
        return 64'h8000_0000_0000_0000;
      end
      if (ue < 0) return 64'd0;
      mg = {11'b0, 1'b1, b[51:0]};
      if (ue >= 52) mg = mg << (ue - 52);
      else mg = mg >> (52 - ue);
      return b[63] ? -mg : mg;
    endfunction

    function void note_request(logic [63:0] raw, logic last);
      conv_result_t r;
      logic [63:0]  ival;
      logic [63:0]  dbits;
      logic         is_int;
      logic         bad;
      ival = 0;
      dbits = 0;
      is_int = 1'b1;
      bad = 1'b0;
      case (src)
        SRC_F32: begin is_int = 1'b0; dbits = widen_f32(raw[31:0]); end
        SRC_F64: begin is_int = 1'b0; dbits = raw; end
        SRC_I8:  ival = {{56{raw[7]}}, raw[7:0]};
        SRC_U8:  ival = {56'b0, raw[7:0]};
        SRC_I16: ival = {{48{raw[15]}}, raw[15:0]};
        SRC_U16: ival = {48'b0, raw[15:0]};
        SRC_I32: ival = {{32{raw[31]}}, raw[31:0]};
        SRC_U32: ival = {32'b0, raw[31:0]};
        SRC_I64, SRC_U64: ival = raw;
        default: begin is_int = 1'b0; bad = 1'b1; end
      endcase
      r.last = last;
      r.rflag = 1'b0;
      r.terr = 1'b0;
      if (tgt == TGT_INT || tgt == TGT_DBL) begin
        r.terr = bad;
        if (bad) r.value = 0;
        else if (tgt == TGT_INT) r.value = is_int ? ival : real_to_int(dbits, r.rflag);
        else if (!is_int) r.value = dbits;
        else if (src == SRC_U64 || !ival[63]) r.value = int_to_real(1'b0, ival);
        else r.value = int_to_real(1'b1, -ival);
      end else begin
        r.value = raw;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] data, logic last, logic [1:0] user);
      conv_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: value_bits %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      matched++;
      if (data !== e.value) begin
        $error("value_bits: expected %h, actual %h", e.value, data);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_out: expected %b, actual %b", e.last, last);
        errors++;
      end
      if (user[0] !== e.terr) begin
        $error("type_error: expected %b, actual %b", e.terr, user[0]);
        errors++;
      end
      if (user[1] !== e.rflag) begin
        $error("range_flag: expected %b, actual %b", e.rflag, user[1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // raw_bits
  logic        in_tlast;   // last_in
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // value_bits
  logic        out_tlast;  // last_out
  logic [1:0]  out_tuser;  // {range_flag, type_error}
  logic        cfg_we;
  logic        cfg_index;
  logic [3:0]  cfg_wdata;

  conv_scoreboard sb;
  bit idle_en;
  int hold_cycles;
  int stall_left;

  numeric_element_type_converter_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("numeric_element_type_converter_unit_tb: done, errors");
    $finish;
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(0, 13);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  task automatic send_elem(logic [63:0] raw, logic last);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = raw;
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    sb.note_request(raw, last);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_mode(logic [3:0] s, logic [1:0] t);
    drain();
    write_reg(REG_SOURCE, s);
    write_reg(REG_TARGET, {2'b0, t});
  endtask

  // random element with float exponents steered toward the edges
  function automatic logic [63:0] rand_elem(logic [3:0] s);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: v = v >> $urandom_range(0, 63);
      2: v[62:52] = (s == SRC_F64) ? 11'(1023 + $urandom_range(0, 66)) : v[62:52];
      3: if (s == SRC_F64) v[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'h000;
         else v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      4: if (s == SRC_F64) v[62:52] = 11'(1023 + 62 + $urandom_range(0, 1));
         else v[30:23] = 8'(127 + $urandom_range(0, 66));
      default: if (s == SRC_F64) v[62:52] = 11'($urandom_range(1000, 1030));
               else v[30:23] = 8'($urandom_range(100, 160));
    endcase
    return v;
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SOURCE;
    cfg_wdata = '0;
    idle_en = 1'b0;
    hold_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset mode is pass through
    send_elem(64'hffff_ffff_ffff_ffff, 1'b1);
    send_elem(64'h0, 1'b0);
    set_mode(SRC_F64, TGT_INT);
    send_elem(64'h43e0_0000_0000_0000, 1'b0);  // 2^63
    send_elem(64'hc3e0_0000_0000_0000, 1'b0);  // -2^63 exact
    send_elem(64'hc3e0_0000_0000_0001, 1'b0);
    send_elem(64'h7ff0_0000_0000_0000, 1'b0);
    send_elem(64'hfff0_0000_0000_0000, 1'b0);
    send_elem(64'h7ff8_0000_0000_0001, 1'b0);
    send_elem(64'hbfe0_0000_0000_0000, 1'b1);  // -0.5
    set_mode(SRC_F32, TGT_DBL);
    send_elem(64'hdead_beef_7f80_0001, 1'b0);  // nan, high bits ignored
    send_elem(64'h0000_0000_0000_0001, 1'b0);  // smallest subnormal
    send_elem(64'h0000_0000_ff80_0000, 1'b0);
    send_elem(64'h0000_0000_8000_0000, 1'b1);
    set_mode(SRC_U64, TGT_DBL);
    send_elem(64'hffff_ffff_ffff_ffff, 1'b0);
    send_elem(64'h0020_0000_0000_0003, 1'b0);  // tie rounding
    set_mode(SRC_I64, TGT_DBL);
    send_elem(64'h8000_0000_0000_0000, 1'b0);
    send_elem(64'h7fff_ffff_ffff_ffff, 1'b0);
    set_mode(SRC_U64, TGT_INT);
    send_elem(64'h8000_0000_0000_0000, 1'b1);
    set_mode(4'd15, TGT_INT);
    send_elem(64'h1234_5678_9abc_def0, 1'b0);

    idle_en = 1'b1;
    for (int t = 0; t < 4; t++) begin
      for (int s = 0; s < 16; s++) begin
        if (t == 3 && s >= 8) idle_en = 1'b0;
        set_mode(4'(s), 2'(t));
        if (t == 0 && s == 1) hold_cycles = 200;
        for (int n = 0; n < 12; n++) begin
          if (t == 1 && s == 9 && n == 6) drain();
          send_elem(rand_elem(4'(s)), 1'(n == 11));
        end
      end
    end

    drain();
    $display("covered all source/target codes incl. unsupported and code 3, %0d results checked",
             sb.matched);
    $display("float edges, rounding ties, long output hold-off and random stalls exercised");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("numeric_element_type_converter_unit_tb: done, clean");
    else
      $display("numeric_element_type_converter_unit_tb: done, errors");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/netc_pkg.sv
rtl/netc_i2d.sv
rtl/netc_d2i.sv
rtl/numeric_element_type_converter_unit.sv
verif/numeric_element_type_converter_unit_tb.sv
